// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hdl/lsu_pkg.sv =====
// ---------------------------------------------------------------------------
// Line splitter package
// Types and constants shared by the front end, queue and back end.
// ---------------------------------------------------------------------------
package lsu_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Input action codes.
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_BINARY_MODE = 1'b0;
  localparam logic REG_SKIP_EMPTY  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // What the back end has to do with one queued item.
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_EOL   = 2'd1,
    OP_FLUSH = 2'd2
  } lsu_op_t;

  // Range that the next UTF-8 continuation byte has to fall into.
  typedef enum logic [2:0] {
    BOUND_ANY  = 3'd0,
    BOUND_A0BF = 3'd1,
    BOUND_809F = 3'd2,
    BOUND_90BF = 3'd3,
    BOUND_808F = 3'd4
  } lsu_bound_t;

  typedef struct packed {
    lsu_op_t    op;
    logic [7:0] data;
  } lsu_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lsu_q_status_t;

  typedef struct packed {
    logic binary_mode;
    logic skip_empty_lines;
  } lsu_cfg_t;

endpackage

// ===== hdl/lsu_front.sv =====
// ---------------------------------------------------------------------------
// Line splitter front end
// Accepts input transfers, classifies them and swallows the LF of a CR LF.
// ---------------------------------------------------------------------------
module lsu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [7:0]            in_byte,
  input  lsu_pkg::lsu_q_status_t q_status,
  output logic                  push,
  output lsu_pkg::lsu_item_t    push_item
);

  logic after_cr;
  logic after_cr_next;
  logic accept;
  logic is_lf;
  logic is_cr;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign is_lf    = (action == lsu_pkg::ACT_BYTE) && (in_byte == lsu_pkg::CH_LF);
  assign is_cr    = (action == lsu_pkg::ACT_BYTE) && (in_byte == lsu_pkg::CH_CR);

  always_comb begin
    push_item.data = in_byte;
    if (action == lsu_pkg::ACT_FLUSH) begin
      push_item.op = lsu_pkg::OP_FLUSH;
    end else if (is_lf || is_cr) begin
      push_item.op = lsu_pkg::OP_EOL;
    end else begin
      push_item.op = lsu_pkg::OP_BYTE;
    end
  end

  // An LF right after a line-ending CR produces nothing downstream.
  assign push = accept && !(is_lf && after_cr);

  always_comb begin
    after_cr_next = after_cr;
    if (accept) begin
      after_cr_next = is_cr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_cr <= 1'b0;
    end else begin
      after_cr <= after_cr_next;
    end
  end

endmodule

// ===== hdl/lsu_queue.sv =====
// ---------------------------------------------------------------------------
// Line splitter item queue
// Small register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module lsu_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lsu_pkg::lsu_item_t     push_item,
  input  logic                   pop,
  output lsu_pkg::lsu_item_t     head,
  output lsu_pkg::lsu_q_status_t status
);

  lsu_pkg::lsu_item_t                 entries [lsu_pkg::QUEUE_DEPTH];
  logic [lsu_pkg::QPTR_W-1:0]         wr_ptr;
  logic [lsu_pkg::QPTR_W-1:0]         rd_ptr;
  logic [lsu_pkg::QCNT_W-1:0]         count;
  logic [lsu_pkg::QCNT_W-1:0]         count_next;

  localparam logic [lsu_pkg::QCNT_W-1:0] CNT_FULL = lsu_pkg::QCNT_W'(lsu_pkg::QUEUE_DEPTH);
  localparam logic [lsu_pkg::QPTR_W-1:0] PTR_LAST = lsu_pkg::QPTR_W'(lsu_pkg::QUEUE_DEPTH - 1);

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/lsu_back.sv =====
// ---------------------------------------------------------------------------
// Line splitter back end
// Tracks line and UTF-8 state and drives the registered result channel.
// ---------------------------------------------------------------------------
module lsu_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic                   cfg_data,
  input  lsu_pkg::lsu_item_t     head,
  input  lsu_pkg::lsu_q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [7:0]             out_byte,
  output logic                   line_ok,
  output logic                   line_empty
);

  lsu_pkg::lsu_cfg_t  cfg;
  logic               line_has_bytes;
  logic               line_has_bytes_next;
  logic [1:0]         cont_needed;
  logic [1:0]         cont_needed_next;
  lsu_pkg::lsu_bound_t next_byte_bound;
  lsu_pkg::lsu_bound_t next_byte_bound_next;
  logic               line_bad;
  logic               line_bad_next;

  logic               emit;
  logic               res_kind;
  logic [7:0]         res_byte;
  logic               res_ok;
  logic               res_empty;
  logic               cur_ok;
  logic               cont_in_range;
  logic [7:0]         b;

  assign pop = !q_status.empty && (!out_valid || !out_stall);
  assign b   = head.data;

  assign cur_ok = cfg.binary_mode || (!line_bad && (cont_needed == 2'd0));

  always_comb begin
    case (next_byte_bound)
      lsu_pkg::BOUND_A0BF: cont_in_range = (b >= 8'hA0) && (b <= 8'hBF);
      lsu_pkg::BOUND_809F: cont_in_range = (b >= 8'h80) && (b <= 8'h9F);
      lsu_pkg::BOUND_90BF: cont_in_range = (b >= 8'h90) && (b <= 8'hBF);
      lsu_pkg::BOUND_808F: cont_in_range = (b >= 8'h80) && (b <= 8'h8F);
      default:             cont_in_range = (b >= 8'h80) && (b <= 8'hBF);
    endcase
  end

  always_comb begin
    line_has_bytes_next  = line_has_bytes;
    cont_needed_next     = cont_needed;
    next_byte_bound_next = next_byte_bound;
    line_bad_next        = line_bad;
    emit                 = 1'b0;
    res_kind             = lsu_pkg::KIND_EOL;
    res_byte             = 8'h00;
    res_ok               = cur_ok;
    res_empty            = !line_has_bytes;

    case (head.op)
      lsu_pkg::OP_BYTE: begin
        emit                = 1'b1;
        res_kind            = lsu_pkg::KIND_BYTE;
        res_byte            = b;
        res_ok              = 1'b0;
        res_empty           = 1'b0;
        line_has_bytes_next = 1'b1;
        if (!line_bad) begin
          if (cont_needed != 2'd0) begin
            next_byte_bound_next = lsu_pkg::BOUND_ANY;
            if (cont_in_range) begin
              cont_needed_next = cont_needed - 2'd1;
            end else begin
              line_bad_next    = 1'b1;
              cont_needed_next = 2'd0;
            end
          end else if (b inside {[8'hC2:8'hDF]}) begin
            cont_needed_next     = 2'd1;
            next_byte_bound_next = lsu_pkg::BOUND_ANY;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            cont_needed_next = 2'd2;
            if (b == 8'hE0) begin
              next_byte_bound_next = lsu_pkg::BOUND_A0BF;
            end else if (b == 8'hED) begin
              next_byte_bound_next = lsu_pkg::BOUND_809F;
            end else begin
              next_byte_bound_next = lsu_pkg::BOUND_ANY;
            end
          end else if (b inside {[8'hF0:8'hF4]}) begin
            cont_needed_next = 2'd3;
            if (b == 8'hF0) begin
              next_byte_bound_next = lsu_pkg::BOUND_90BF;
            end else if (b == 8'hF4) begin
              next_byte_bound_next = lsu_pkg::BOUND_808F;
            end else begin
              next_byte_bound_next = lsu_pkg::BOUND_ANY;
            end
          end else if (b[7]) begin
            line_bad_next = 1'b1;
          end
        end
      end
      lsu_pkg::OP_EOL, lsu_pkg::OP_FLUSH: begin
        // A flush only closes a line that holds bytes.
        if ((head.op == lsu_pkg::OP_EOL) || line_has_bytes) begin
          emit = !(!line_has_bytes && cfg.skip_empty_lines);
        end
        line_has_bytes_next  = 1'b0;
        cont_needed_next     = 2'd0;
        next_byte_bound_next = lsu_pkg::BOUND_ANY;
        line_bad_next        = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg             <= '0;
      line_has_bytes  <= 1'b0;
      cont_needed     <= 2'd0;
      next_byte_bound <= lsu_pkg::BOUND_ANY;
      line_bad        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lsu_pkg::REG_BINARY_MODE) begin
          cfg.binary_mode <= cfg_data;
        end else begin
          cfg.skip_empty_lines <= cfg_data;
        end
      end
      if (pop) begin
        line_has_bytes  <= line_has_bytes_next;
        cont_needed     <= cont_needed_next;
        next_byte_bound <= next_byte_bound_next;
        line_bad        <= line_bad_next;
        out_valid       <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind       <= res_kind;
      out_byte   <= res_byte;
      line_ok    <= res_ok;
      line_empty <= res_empty;
    end
  end

endmodule

// ===== hdl/line_splitter_utf8_check_unit.sv =====
// ---------------------------------------------------------------------------
// Line splitter with UTF-8 check
// Splits a byte stream into lines and flags each line's UTF-8 validity.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, action, in_byte) carries one
// data byte or an end-of-input flush per transfer. The output channel
// (out_valid, out_stall, kind, out_byte, line_ok, line_empty) carries line
// bytes (kind 0) and end-of-line markers (kind 1), at most one result per
// input transfer. LF, CR and CR LF each end a line; the LF of a CR LF pair
// gives no result. A flush closes a pending non-empty line.
// Throughput is one input transfer per cycle while in_stall is low. A result
// passes through the two-entry item queue, where it waits at the head, and
// is then loaded into the output register. When the receiver holds
// out_stall, the output register keeps its result, the queue fills, and
// once it holds two items in_stall rises until the receiver takes the
// result. Reset clears the line state, the queue and both configuration
// registers (binary_mode, skip_empty_lines). The configuration port is to
// be written only while the block holds no work; the user is bound to
// this, and the block itself does not enforce it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module line_splitter_utf8_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic       line_ok,
  output logic       line_empty
);

  // Items travel from the front end through the queue to the back end.
  lsu_pkg::lsu_item_t     push_item;
  lsu_pkg::lsu_item_t     head;
  lsu_pkg::lsu_q_status_t q_status;
  logic                   push;
  logic                   pop;

  // The front end classifies each transfer and drops a swallowed LF.
  lsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .in_byte   (in_byte),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  lsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back end owns line state, UTF-8 state and the configuration.
  lsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .line_ok    (line_ok),
    .line_empty (line_empty)
  );

  // The queue can never be full and empty at once.
  `ASSERT_NEVER(a_queue_status, clk, rst, q_status.full && q_status.empty)
  // An ordinary data byte that is taken in is waiting in the queue in the next cycle.
  `ASSERT_PROP(a_byte_queued, clk, rst,
    (in_valid && !in_stall && (action == lsu_pkg::ACT_BYTE) &&
     (in_byte != lsu_pkg::CH_LF) && (in_byte != lsu_pkg::CH_CR)) |=> !q_status.empty)
  // An empty line always passes the UTF-8 check.
  `ASSERT_PROP(a_empty_line_ok, clk, rst,
    (out_valid && (kind == lsu_pkg::KIND_EOL) && line_empty) |-> line_ok)
  // A line byte carries no marker flags.
  `ASSERT_PROP(a_byte_flags_clear, clk, rst,
    (out_valid && (kind == lsu_pkg::KIND_BYTE)) |-> (!line_ok && !line_empty))

endmodule
